/* hdl/kin_pkg.sv */
// ---------------------------------------------------------------------------
// kin_pkg: shared types and constants of the keyword/number/identifier lexer
// Token kinds, character codes, the keyword table and the token queue sizes.
// ---------------------------------------------------------------------------
`default_nettype none

package kin_pkg;

    // Token kinds as they appear on the output channel
    localparam logic [4:0] KIND_INT     = 5'd0;
    localparam logic [4:0] KIND_ID      = 5'd1;
    localparam logic [4:0] KIND_NUM     = 5'd2;
    localparam logic [4:0] KIND_IF      = 5'd3;
    localparam logic [4:0] KIND_ELSE    = 5'd4;
    localparam logic [4:0] KIND_RETURN  = 5'd5;
    localparam logic [4:0] KIND_ASSIGN  = 5'd6;
    localparam logic [4:0] KIND_PLUS    = 5'd7;
    localparam logic [4:0] KIND_MINUS   = 5'd8;
    localparam logic [4:0] KIND_STAR    = 5'd9;
    localparam logic [4:0] KIND_SLASH   = 5'd10;
    localparam logic [4:0] KIND_LPAREN  = 5'd11;
    localparam logic [4:0] KIND_RPAREN  = 5'd12;
    localparam logic [4:0] KIND_LBRACE  = 5'd13;
    localparam logic [4:0] KIND_RBRACE  = 5'd14;
    localparam logic [4:0] KIND_SEMI    = 5'd15;
    localparam logic [4:0] KIND_GREATER = 5'd16;
    localparam logic [4:0] KIND_EOF     = 5'd17;
    localparam logic [4:0] KIND_WHILE   = 5'd18;
    localparam logic [4:0] KIND_ERROR   = 5'd19;

    // ASCII codes the scanner recognises
    localparam logic [7:0] CHAR_ASSIGN  = 8'h3D;
    localparam logic [7:0] CHAR_PLUS    = 8'h2B;
    localparam logic [7:0] CHAR_MINUS   = 8'h2D;
    localparam logic [7:0] CHAR_STAR    = 8'h2A;
    localparam logic [7:0] CHAR_SLASH   = 8'h2F;
    localparam logic [7:0] CHAR_LPAREN  = 8'h28;
    localparam logic [7:0] CHAR_RPAREN  = 8'h29;
    localparam logic [7:0] CHAR_LBRACE  = 8'h7B;
    localparam logic [7:0] CHAR_RBRACE  = 8'h7D;
    localparam logic [7:0] CHAR_SEMI    = 8'h3B;
    localparam logic [7:0] CHAR_GREATER = 8'h3E;
    localparam logic [7:0] CHAR_SPACE   = 8'h20;
    localparam logic [7:0] CHAR_TAB     = 8'h09;
    localparam logic [7:0] CHAR_NEWLINE = 8'h0A;
    localparam logic [7:0] CHAR_VTAB    = 8'h0B;
    localparam logic [7:0] CHAR_FFEED   = 8'h0C;
    localparam logic [7:0] CHAR_CRET    = 8'h0D;

    // Keyword table: text packed first character in the low byte
    localparam int KEYWORD_COUNT = 5;
    localparam logic [63:0] KEYWORD_TEXT [KEYWORD_COUNT] = '{
        64'h0000_0000_0074_6E69,   // int
        64'h0000_0000_0000_6669,   // if
        64'h0000_0000_6573_6C65,   // else
        64'h0000_6E72_7574_6572,   // return
        64'h0000_0065_6C69_6877    // while
    };
    localparam logic [15:0] KEYWORD_LEN [KEYWORD_COUNT] = '{
        16'd3, 16'd2, 16'd4, 16'd6, 16'd5
    };
    localparam logic [4:0] KEYWORD_KIND [KEYWORD_COUNT] = '{
        KIND_INT, KIND_IF, KIND_ELSE, KIND_RETURN, KIND_WHILE
    };

    // One byte can give at most three tokens; the scanner has four slots
    localparam int TOKEN_SLOTS     = 4;
    localparam int TOKENS_MAX      = 3;
    localparam int FIFO_DEPTH      = 8;
    localparam int FIFO_PTR_BITS   = 3;
    localparam int FIFO_COUNT_BITS = 4;

    typedef struct packed {
        logic [4:0]  kind;
        logic [15:0] line;
        logic [15:0] column;
        logic [15:0] length;
        logic        last;
    } token_t;

    typedef struct packed {
        logic [TOKEN_SLOTS-1:0] valid;
        token_t [TOKEN_SLOTS-1:0] tok;
    } token_group_t;

endpackage

`default_nettype wire

/* hdl/kin_word_class.sv */
// ---------------------------------------------------------------------------
// kin_word_class: keyword classifier
// Compares the length and leading characters of a word against the keyword
// table and gives the keyword kind, or identifier when nothing matches.
// ---------------------------------------------------------------------------
`default_nettype none

module kin_word_class #(
    parameter int KEYWORD_MAX_LEN = 6
) (
    input  wire logic [15:0]                  run_length,
    input  wire logic [8*KEYWORD_MAX_LEN-1:0] keyword_prefix,
    output logic      [4:0]                   word_kind
);

    logic [63:0] prefix_wide;

    assign prefix_wide = 64'(keyword_prefix);

    // Words longer than the stored prefix are always identifiers.
    always_comb
    begin
        word_kind = kin_pkg::KIND_ID;
        if (run_length <= 16'(KEYWORD_MAX_LEN))
        begin
            for (int i = kin_pkg::KEYWORD_COUNT - 1; i >= 0; i--)
            begin
                if (run_length == kin_pkg::KEYWORD_LEN[i] &&
                    prefix_wide == kin_pkg::KEYWORD_TEXT[i])
                begin
                    word_kind = kin_pkg::KEYWORD_KIND[i];
                end
            end
        end
    end

endmodule

`default_nettype wire

/* hdl/kin_scanner.sv */
// ---------------------------------------------------------------------------
// kin_scanner: input register and single-pass scanning step
// Holds the scan state and turns one registered byte into up to three tokens
// placed in four fixed slots: flushed run, operator or error, final flush,
// end-of-file.
// ---------------------------------------------------------------------------
`default_nettype none

module kin_scanner #(
    parameter int POSITION_BITS   = 16,
    parameter int KEYWORD_MAX_LEN = 6
) (
    input  wire logic                   clk,
    input  wire logic                   rst_n,
    input  wire logic                   in_valid,
    output logic                        in_ready,
    input  wire logic [7:0]             in_byte,
    input  wire logic                   in_byte_valid,
    input  wire logic                   in_end,
    input  wire logic                   space_ok,
    output logic                        group_write,
    output kin_pkg::token_group_t       group
);

    localparam logic [1:0] MODE_IDLE   = 2'd0;
    localparam logic [1:0] MODE_NUMBER = 2'd1;
    localparam logic [1:0] MODE_WORD   = 2'd2;
    localparam logic [1:0] MODE_HALTED = 2'd3;

    localparam int PREFIX_BITS = 8 * KEYWORD_MAX_LEN;
    localparam logic [POSITION_BITS-1:0] POS_MAX = '1;
    localparam logic [POSITION_BITS-1:0] POS_ONE = POSITION_BITS'(1);
    localparam logic [15:0] RUN_MAX = (POSITION_BITS < 16) ?
        16'((64'd1 << POSITION_BITS) - 64'd1) : 16'hFFFF;

    // Input register
    logic       in_valid_reg;
    logic [7:0] byte_reg;
    logic       byte_valid_reg;
    logic       end_reg;
    logic       consume;

    // Scan state
    logic [1:0]               mode_reg,   mode_next,   mode_mid;
    logic [POSITION_BITS-1:0] line_reg,   line_next,   line_mid;
    logic [POSITION_BITS-1:0] col_reg,    col_next,    col_mid;
    logic [POSITION_BITS-1:0] start_reg,  start_next,  start_mid;
    logic [15:0]              run_reg,    run_next,    run_mid;
    logic [PREFIX_BITS-1:0]   prefix_reg, prefix_next, prefix_mid;

    logic       is_digit, is_alpha, is_space, is_op;
    logic [4:0] op_code;
    logic       flush_first, op_valid, hit_error, end_eff;
    logic [4:0] op_kind;
    logic [4:0] kind_now, kind_after;
    logic [1:0] last_slot;

    assign consume  = in_valid_reg && space_ok;
    assign in_ready = !in_valid_reg || space_ok;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (in_valid && in_ready)
        begin
            in_valid_reg <= 1'b1;
        end
        else if (consume)
        begin
            in_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            byte_reg       <= in_byte;
            byte_valid_reg <= in_byte_valid;
            end_reg        <= in_end;
        end
    end

    // Character classes
    assign is_digit = (byte_reg >= 8'h30) && (byte_reg <= 8'h39);
    assign is_alpha = ((byte_reg >= 8'h41) && (byte_reg <= 8'h5A)) ||
                      ((byte_reg >= 8'h61) && (byte_reg <= 8'h7A));
    assign is_space = (byte_reg == kin_pkg::CHAR_SPACE)   ||
                      (byte_reg == kin_pkg::CHAR_TAB)     ||
                      (byte_reg == kin_pkg::CHAR_NEWLINE) ||
                      (byte_reg == kin_pkg::CHAR_VTAB)    ||
                      (byte_reg == kin_pkg::CHAR_FFEED)   ||
                      (byte_reg == kin_pkg::CHAR_CRET);

    // Operator and punctuator decode
    always_comb
    begin
        is_op   = 1'b1;
        op_code = kin_pkg::KIND_ERROR;
        case (byte_reg)
            kin_pkg::CHAR_ASSIGN:  op_code = kin_pkg::KIND_ASSIGN;
            kin_pkg::CHAR_PLUS:    op_code = kin_pkg::KIND_PLUS;
            kin_pkg::CHAR_MINUS:   op_code = kin_pkg::KIND_MINUS;
            kin_pkg::CHAR_STAR:    op_code = kin_pkg::KIND_STAR;
            kin_pkg::CHAR_SLASH:   op_code = kin_pkg::KIND_SLASH;
            kin_pkg::CHAR_LPAREN:  op_code = kin_pkg::KIND_LPAREN;
            kin_pkg::CHAR_RPAREN:  op_code = kin_pkg::KIND_RPAREN;
            kin_pkg::CHAR_LBRACE:  op_code = kin_pkg::KIND_LBRACE;
            kin_pkg::CHAR_RBRACE:  op_code = kin_pkg::KIND_RBRACE;
            kin_pkg::CHAR_SEMI:    op_code = kin_pkg::KIND_SEMI;
            kin_pkg::CHAR_GREATER: op_code = kin_pkg::KIND_GREATER;
            default:               is_op   = 1'b0;
        endcase
    end

    // Keyword classification of the run held now and of the run after this byte
    kin_word_class #(
        .KEYWORD_MAX_LEN (KEYWORD_MAX_LEN)
    ) u_class_now (
        .run_length     (run_reg),
        .keyword_prefix (prefix_reg),
        .word_kind      (kind_now)
    );

    kin_word_class #(
        .KEYWORD_MAX_LEN (KEYWORD_MAX_LEN)
    ) u_class_after (
        .run_length     (run_mid),
        .keyword_prefix (prefix_mid),
        .word_kind      (kind_after)
    );

    // Character step: flush a finished run, then extend, start, skip or emit.
    always_comb
    begin
        mode_mid    = mode_reg;
        line_mid    = line_reg;
        col_mid     = col_reg;
        start_mid   = start_reg;
        run_mid     = run_reg;
        prefix_mid  = prefix_reg;
        flush_first = 1'b0;
        op_valid    = 1'b0;
        op_kind     = kin_pkg::KIND_ERROR;
        hit_error   = 1'b0;
        if (mode_reg != MODE_HALTED && byte_valid_reg)
        begin
            if ((mode_reg == MODE_NUMBER && !is_digit) ||
                (mode_reg == MODE_WORD && !is_digit && !is_alpha))
            begin
                flush_first = 1'b1;
                mode_mid    = MODE_IDLE;
            end

            if (mode_mid != MODE_IDLE)
            begin
                for (int i = 0; i < KEYWORD_MAX_LEN; i++)
                begin
                    if (run_reg == 16'(i))
                    begin
                        prefix_mid[8*i +: 8] = byte_reg;
                    end
                end
                run_mid = (run_reg >= RUN_MAX) ? RUN_MAX : run_reg + 16'd1;
                col_mid = (col_reg == POS_MAX) ? POS_MAX : col_reg + POS_ONE;
            end
            else if (is_space)
            begin
                if (byte_reg == kin_pkg::CHAR_NEWLINE)
                begin
                    line_mid = (line_reg == POS_MAX) ? POS_MAX : line_reg + POS_ONE;
                    col_mid  = POS_ONE;
                end
                else
                begin
                    col_mid = (col_reg == POS_MAX) ? POS_MAX : col_reg + POS_ONE;
                end
            end
            else if (is_digit || is_alpha)
            begin
                mode_mid       = is_digit ? MODE_NUMBER : MODE_WORD;
                start_mid      = col_reg;
                run_mid        = 16'd1;
                prefix_mid     = '0;
                prefix_mid[7:0] = byte_reg;
                col_mid = (col_reg == POS_MAX) ? POS_MAX : col_reg + POS_ONE;
            end
            else
            begin
                op_valid = 1'b1;
                if (is_op)
                begin
                    op_kind = op_code;
                    col_mid = (col_reg == POS_MAX) ? POS_MAX : col_reg + POS_ONE;
                end
                else
                begin
                    hit_error = 1'b1;
                    mode_mid  = MODE_HALTED;
                end
            end
        end
    end

    // End of source handling and token slot assembly
    always_comb
    begin
        line_next   = line_mid;
        col_next    = col_mid;
        start_next  = start_mid;
        run_next    = run_mid;
        prefix_next = prefix_mid;
        mode_next   = mode_mid;
        end_eff     = end_reg && !hit_error && (mode_reg != MODE_HALTED);
        group       = '0;
        last_slot   = 2'd0;

        group.valid[0]       = flush_first;
        group.tok[0].kind    = (mode_reg == MODE_NUMBER) ? kin_pkg::KIND_NUM : kind_now;
        group.tok[0].line    = 16'(line_reg);
        group.tok[0].column  = 16'(start_reg);
        group.tok[0].length  = run_reg;

        group.valid[1]       = op_valid;
        group.tok[1].kind    = op_kind;
        group.tok[1].line    = 16'(line_reg);
        group.tok[1].column  = 16'(col_reg);
        group.tok[1].length  = 16'd1;

        group.valid[2]       = end_eff &&
                               (mode_mid == MODE_NUMBER || mode_mid == MODE_WORD);
        group.tok[2].kind    = (mode_mid == MODE_NUMBER) ? kin_pkg::KIND_NUM : kind_after;
        group.tok[2].line    = 16'(line_mid);
        group.tok[2].column  = 16'(start_mid);
        group.tok[2].length  = run_mid;

        group.valid[3]       = end_eff;
        group.tok[3].kind    = kin_pkg::KIND_EOF;
        group.tok[3].line    = 16'(line_mid);
        group.tok[3].column  = 16'(col_mid);
        group.tok[3].length  = 16'd0;

        if (end_eff)
        begin
            mode_next = MODE_HALTED;
        end

        // The highest filled slot closes the transaction's run of tokens.
        for (int k = 0; k < kin_pkg::TOKEN_SLOTS; k++)
        begin
            if (group.valid[k])
            begin
                last_slot = 2'(k);
            end
        end
        if (group.valid != '0)
        begin
            group.tok[last_slot].last = 1'b1;
        end
    end

    assign group_write = consume;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg   <= MODE_IDLE;
            line_reg   <= POS_ONE;
            col_reg    <= POS_ONE;
            start_reg  <= POS_ONE;
            run_reg    <= 16'd0;
            prefix_reg <= '0;
        end
        else if (consume)
        begin
            mode_reg   <= mode_next;
            line_reg   <= line_next;
            col_reg    <= col_next;
            start_reg  <= start_next;
            run_reg    <= run_next;
            prefix_reg <= prefix_next;
        end
    end

endmodule

`default_nettype wire

/* hdl/kin_token_fifo.sv */
// ---------------------------------------------------------------------------
// kin_token_fifo: token queue
// Packs the filled slots of one scanned byte into consecutive entries and
// presents one token per cycle on the output side while out_ready is high.
// ---------------------------------------------------------------------------
`default_nettype none

module kin_token_fifo (
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  group_write,
    input  wire kin_pkg::token_group_t group,
    output logic                       space_ok,
    output logic                       out_valid,
    input  wire logic                  out_ready,
    output kin_pkg::token_t            out_token
);

    localparam int PB = kin_pkg::FIFO_PTR_BITS;
    localparam int CB = kin_pkg::FIFO_COUNT_BITS;

    kin_pkg::token_t entry_mem [kin_pkg::FIFO_DEPTH];

    logic [PB-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PB-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CB-1:0] count_reg,  count_next;
    logic [1:0]    slot_offset [kin_pkg::TOKEN_SLOTS];
    logic [2:0]    push_count;
    logic          pop;

    // Offset of each filled slot among the filled slots before it
    always_comb
    begin
        push_count = 3'd0;
        for (int k = 0; k < kin_pkg::TOKEN_SLOTS; k++)
        begin
            slot_offset[k] = push_count[1:0];
            push_count     = push_count + {2'b00, group.valid[k]};
        end
        if (!group_write)
        begin
            push_count = 3'd0;
        end
    end

    assign pop       = out_valid && out_ready;
    assign out_valid = (count_reg != '0);
    assign out_token = entry_mem[rd_ptr_reg];
    assign space_ok  = (count_reg <= CB'(kin_pkg::FIFO_DEPTH - kin_pkg::TOKENS_MAX));

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg + PB'(push_count);
        rd_ptr_next = pop ? rd_ptr_reg + PB'(1) : rd_ptr_reg;
        count_next  = count_reg + CB'(push_count) - CB'(pop);
    end

    // Token storage
    always_ff @(posedge clk)
    begin
        if (group_write)
        begin
            for (int k = 0; k < kin_pkg::TOKEN_SLOTS; k++)
            begin
                if (group.valid[k])
                begin
                    entry_mem[PB'(wr_ptr_reg + PB'(slot_offset[k]))] <= group.tok[k];
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

endmodule

`default_nettype wire

/* hdl/keyword_number_identifier_lexer.sv */
// ---------------------------------------------------------------------------
// keyword_number_identifier_lexer: streaming lexer for a small C-like language
// Turns source bytes into number, word, keyword, operator, error and
// end-of-file tokens with start line, start column and length.
//
//   channel | dir | tdata                           | tuser          | tlast
//   s_axis  | in  | [7:0] data_byte                 | byte_valid     | end_of_source
//   m_axis  | out | [15:0] line [31:16] column      | [4:0] kind     | last_of_run
//           |     | [47:32] length                  |                |
//
// A byte is taken every cycle while the token queue has room for three
// tokens; it is scanned from the input register and its tokens are written
// into the queue when there is room. Tokens leave one per cycle while the
// output is ready, so bytes that yield more than one token hold the input
// back once the queue fills. Reset is asynchronous and needs no clearing
// pass. A stalled output only backs up the queue; scan state is never lost.
// ---------------------------------------------------------------------------
`default_nettype none

module keyword_number_identifier_lexer #(
    parameter int POSITION_BITS   = 16,
    parameter int KEYWORD_MAX_LEN = 6
) (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [7:0]  s_tdata,   // [7:0] data_byte
    input  wire logic        s_tuser,   // [0] byte_valid
    input  wire logic        s_tlast,
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic      [47:0] m_tdata,   // [15:0] token_line, [31:16] token_column,
                                        // [47:32] token_length
    output logic      [4:0]  m_tuser,   // [4:0] token_kind
    output logic             m_tlast
);

    kin_pkg::token_group_t group;
    kin_pkg::token_t       out_token;
    logic                  group_write;
    logic                  space_ok;

    // Scanner with its input register
    kin_scanner #(
        .POSITION_BITS   (POSITION_BITS),
        .KEYWORD_MAX_LEN (KEYWORD_MAX_LEN)
    ) u_scanner (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (s_tvalid),
        .in_ready      (s_tready),
        .in_byte       (s_tdata),
        .in_byte_valid (s_tuser),
        .in_end        (s_tlast),
        .space_ok      (space_ok),
        .group_write   (group_write),
        .group         (group)
    );

    // Token queue feeding the output channel
    kin_token_fifo u_fifo (
        .clk         (clk),
        .rst_n       (rst_n),
        .group_write (group_write),
        .group       (group),
        .space_ok    (space_ok),
        .out_valid   (m_tvalid),
        .out_ready   (m_tready),
        .out_token   (out_token)
    );

    // Output transaction fields
    assign m_tdata = {out_token.length, out_token.column, out_token.line};
    assign m_tuser = out_token.kind;
    assign m_tlast = out_token.last;

endmodule

`default_nettype wire
